// File: sv/ifds_pkg.sv
// Shared types, constants and calibration table for the IMU frame decoder.
package ifds_pkg;

  localparam int MAX_IMUS    = 32;
  localparam int REC_W       = $clog2(MAX_IMUS);
  localparam int WORDS       = 9;
  localparam int WORD_IDX_W  = $clog2(WORDS);
  localparam int QUEUE_DEPTH = 2;
  localparam int CAL_IMUS    = 17;
  localparam int CAL_ENTRIES = CAL_IMUS * 3;

  localparam int IMU_COUNT_W = 6;
  localparam int REC_BYTES_W = 7;
  localparam int SCALE_W     = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_IDX_W-1:0] REG_IMU_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_BYTES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_SCALE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_SCALE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAG_SCALE    = 3'd4;

  localparam logic [IMU_COUNT_W-1:0] IMU_COUNT_RST    = 6'd17;
  localparam logic [REC_BYTES_W-1:0] RECORD_BYTES_RST = 7'd19;
  localparam logic [SCALE_W-1:0]     ACC_SCALE_RST    = 24'd2048;
  localparam logic [SCALE_W-1:0]     GYRO_SCALE_RST   = 24'd1024033;
  localparam logic [SCALE_W-1:0]     MAG_SCALE_RST    = 24'd2457862;

  localparam logic [REC_BYTES_W-1:0] REC_BYTES_MIN = 7'd19;
  localparam logic [REC_BYTES_W-1:0] REC_BYTES_MAX = 7'd64;
  localparam logic [5:0]             LAST_DATA_POS = 6'd18;

  localparam logic [1:0] KIND_ACC  = 2'd0;
  localparam logic [1:0] KIND_GYRO = 2'd1;
  localparam logic [1:0] KIND_MAG  = 2'd2;

  localparam logic [7:0] CAL_TABLE [CAL_ENTRIES] = '{
    8'd181, 8'd181, 8'd169, 8'd174, 8'd175, 8'd163, 8'd175, 8'd174, 8'd163,
    8'd176, 8'd179, 8'd166, 8'd181, 8'd183, 8'd170, 8'd177, 8'd178, 8'd166,
    8'd170, 8'd173, 8'd159, 8'd170, 8'd172, 8'd159, 8'd177, 8'd178, 8'd167,
    8'd176, 8'd178, 8'd166, 8'd177, 8'd177, 8'd165, 8'd176, 8'd177, 8'd164,
    8'd179, 8'd179, 8'd168, 8'd174, 8'd174, 8'd162, 8'd182, 8'd183, 8'd170,
    8'd171, 8'd169, 8'd158, 8'd178, 8'd180, 8'd168
  };

  typedef struct packed {
    logic [IMU_COUNT_W-1:0] imu_count;
    logic [REC_BYTES_W-1:0] record_bytes;
  } frame_cfg_t;

  typedef struct packed {
    logic [SCALE_W-1:0] acc_scale;
    logic [SCALE_W-1:0] gyro_scale;
    logic [SCALE_W-1:0] mag_scale;
  } scale_cfg_t;

  typedef struct packed {
    logic [REC_W-1:0]          rec;
    logic                      last;
    logic                      capture;
    logic [WORDS-1:0][15:0]    raw;
  } job_t;

  // Magnetometer calibration byte for one IMU and axis; 128 past the table.
  function automatic logic [7:0] cal_byte(input logic [REC_W-1:0] rec,
                                          input logic [1:0] axis);
    logic [REC_W+1:0] idx;
    logic [7:0]       c;
    idx = (REC_W+2)'(rec) * (REC_W+2)'(3) + (REC_W+2)'(axis);
    c = 8'd128;
    if (idx < (REC_W+2)'(CAL_ENTRIES)) begin
      c = CAL_TABLE[idx[$clog2(CAL_ENTRIES)-1:0]];
    end
    return c;
  endfunction

endpackage

// File: sv/ifds_in_if.sv
// Byte input channel: valid/ready with received byte and frame marker.
interface ifds_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// File: sv/ifds_out_if.sv
// Result channel: valid/ready with one record of scaled sensor values.
interface ifds_out_if;
  logic               valid;
  logic               ready;
  logic [4:0]         imu_index;
  logic signed [39:0] acc_x;
  logic signed [39:0] acc_y;
  logic signed [39:0] acc_z;
  logic signed [40:0] gyro_x;
  logic signed [40:0] gyro_y;
  logic signed [40:0] gyro_z;
  logic signed [40:0] mag_x;
  logic signed [40:0] mag_y;
  logic signed [40:0] mag_z;
  logic               last_in_frame;

  modport source (output valid, output imu_index, output acc_x, output acc_y,
                  output acc_z, output gyro_x, output gyro_y, output gyro_z,
                  output mag_x, output mag_y, output mag_z, output last_in_frame,
                  input ready);
  modport sink   (input valid, input imu_index, input acc_x, input acc_y,
                  input acc_z, input gyro_x, input gyro_y, input gyro_z,
                  input mag_x, input mag_y, input mag_z, input last_in_frame,
                  output ready);
endinterface

// File: sv/ifds_front.sv
// Front end: byte/record counting, word assembly and record job creation.
module ifds_front (
  input  logic                  clk,
  input  logic                  rst,
  ifds_in_if.sink               rx,
  input  ifds_pkg::frame_cfg_t  fcfg,
  input  logic                  q_full,
  output logic                  q_push,
  output ifds_pkg::job_t        q_job
);

  logic [5:0]                         byte_position;
  logic [ifds_pkg::REC_W-1:0]         record_position;
  logic [7:0]                         high_byte_hold;
  logic [ifds_pkg::WORDS-1:0][15:0]   raw_words;
  logic                               bias_ready;

  logic [ifds_pkg::IMU_COUNT_W-1:0]   count;
  logic [ifds_pkg::REC_W-1:0]         cnt_last;
  logic [ifds_pkg::REC_BYTES_W-1:0]   rlen;
  logic [5:0]                         pos;
  logic [ifds_pkg::REC_W-1:0]         rec;
  logic                               last;
  logic                               xfer;
  logic [ifds_pkg::WORD_IDX_W-1:0]    widx;
  logic [15:0]                        word;
  logic [6:0]                         pos_inc;

  always_comb begin
    count = fcfg.imu_count;
    if (fcfg.imu_count == '0) begin
      count = ifds_pkg::IMU_COUNT_W'(1);
    end else if (fcfg.imu_count > ifds_pkg::IMU_COUNT_W'(ifds_pkg::MAX_IMUS)) begin
      count = ifds_pkg::IMU_COUNT_W'(ifds_pkg::MAX_IMUS);
    end
    cnt_last = ifds_pkg::REC_W'(count - ifds_pkg::IMU_COUNT_W'(1));
    rlen = fcfg.record_bytes;
    if (fcfg.record_bytes < ifds_pkg::REC_BYTES_MIN) begin
      rlen = ifds_pkg::REC_BYTES_MIN;
    end else if (fcfg.record_bytes > ifds_pkg::REC_BYTES_MAX) begin
      rlen = ifds_pkg::REC_BYTES_MAX;
    end
    pos     = rx.frame_start ? '0 : byte_position;
    rec     = rx.frame_start ? '0 : record_position;
    last    = rec >= cnt_last;
    pos_inc = {1'b0, pos} + 7'd1;
    widx    = ifds_pkg::WORD_IDX_W'(pos[4:1] - 4'd1);
    word    = {high_byte_hold, rx.rx_byte};
  end

  assign rx.ready = !q_full || (byte_position != ifds_pkg::LAST_DATA_POS);
  assign xfer     = rx.valid && rx.ready;
  assign q_push   = xfer && (pos == ifds_pkg::LAST_DATA_POS);

  always_comb begin
    q_job.rec     = rec;
    q_job.last    = last;
    q_job.capture = !bias_ready;
    q_job.raw     = raw_words;
    q_job.raw[ifds_pkg::WORDS-1] = word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      record_position <= '0;
      high_byte_hold  <= '0;
      raw_words       <= '0;
      bias_ready      <= 1'b0;
    end else if (xfer) begin
      if (pos >= 6'd1 && pos <= ifds_pkg::LAST_DATA_POS) begin
        if (pos[0]) begin
          high_byte_hold <= rx.rx_byte;
        end else begin
          raw_words[widx] <= word;
        end
      end
      if (q_push && last) begin
        bias_ready <= 1'b1;
      end
      if (pos_inc >= rlen) begin
        byte_position   <= '0;
        record_position <= last ? '0 : rec + ifds_pkg::REC_W'(1);
      end else begin
        byte_position   <= pos_inc[5:0];
        record_position <= rec;
      end
    end
  end

endmodule

// File: sv/ifds_queue.sv
// Short job queue between front end and back end.
module ifds_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ifds_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output ifds_pkg::job_t  pop_job
);

  localparam int PTR_W = (ifds_pkg::QUEUE_DEPTH > 1) ? $clog2(ifds_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(ifds_pkg::QUEUE_DEPTH + 1);

  ifds_pkg::job_t   slots [ifds_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full    = fill == CNT_W'(ifds_pkg::QUEUE_DEPTH);
  assign q_valid = fill != '0;
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(ifds_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(ifds_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// File: sv/ifds_back.sv
// Back end: shared scaling multiplier pipeline, gyro bias store, output register.
module ifds_back (
  input  logic                  clk,
  input  logic                  rst,
  input  ifds_pkg::scale_cfg_t  scfg,
  input  logic                  q_valid,
  input  ifds_pkg::job_t        q_job,
  output logic                  q_pop,
  ifds_out_if.source            res
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  localparam logic [3:0] ISSUE_END = 4'(ifds_pkg::WORDS);
  localparam logic [3:0] RUN_END   = 4'(ifds_pkg::WORDS + 1);

  logic [1:0]       state;
  logic [3:0]       cnt;
  ifds_pkg::job_t   job;

  logic [2:0][39:0] bias_mem [ifds_pkg::MAX_IMUS];
  logic [ifds_pkg::MAX_IMUS-1:0] bias_vld;
  logic [2:0][39:0] bias_q;
  logic             bias_ok;
  logic [2:0][39:0] cap_row;

  logic                a_vld;
  logic [1:0]          a_kind;
  logic [1:0]          a_axis;
  logic signed [39:0]  p1;
  logic                b_vld;
  logic [1:0]          b_axis;
  logic signed [48:0]  p2;

  logic signed [39:0] acc_r  [3];
  logic signed [40:0] gyro_r [3];
  logic signed [40:0] cal_r  [3];

  logic [1:0]          s_kind;
  logic [1:0]          s_axis;
  logic [15:0]         raw_sel;
  logic [23:0]         scale_sel;
  logic signed [40:0]  prod_a;
  logic signed [39:0]  bias_sel;
  logic signed [40:0]  gyro_diff;
  logic [8:0]          cw;
  logic signed [49:0]  prod_b;
  logic signed [48:0]  rnd;
  logic                out_free;
  logic                finish;

  always_comb begin
    s_kind = ifds_pkg::KIND_MAG;
    s_axis = 2'(cnt - 4'd6);
    if (cnt < 4'd3) begin
      s_kind = ifds_pkg::KIND_ACC;
      s_axis = cnt[1:0];
    end else if (cnt < 4'd6) begin
      s_kind = ifds_pkg::KIND_GYRO;
      s_axis = 2'(cnt - 4'd3);
    end
    raw_sel = job.raw[cnt[ifds_pkg::WORD_IDX_W-1:0]];
    case (s_kind)
      ifds_pkg::KIND_ACC:  scale_sel = scfg.acc_scale;
      ifds_pkg::KIND_GYRO: scale_sel = scfg.gyro_scale;
      default:             scale_sel = scfg.mag_scale;
    endcase
    prod_a    = $signed(raw_sel) * $signed({1'b0, scale_sel});
    bias_sel  = bias_ok ? $signed(bias_q[a_axis]) : 40'sd0;
    gyro_diff = {p1[39], p1} - {bias_sel[39], bias_sel};
    cw        = {1'b0, ifds_pkg::cal_byte(job.rec, a_axis)} + 9'd128;
    prod_b    = p1 * $signed({1'b0, cw});
    rnd       = p2 + 49'sd128;
  end

  assign out_free = !res.valid || res.ready;
  assign finish   = (state == ST_HOLD) && out_free;
  assign q_pop    = (state == ST_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      a_vld     <= 1'b0;
      b_vld     <= 1'b0;
      bias_vld  <= '0;
      res.valid <= 1'b0;
    end else begin
      a_vld <= (state == ST_RUN) && (cnt < ISSUE_END);
      b_vld <= a_vld && (a_kind == ifds_pkg::KIND_MAG);
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            state <= ST_RUN;
            cnt   <= '0;
          end
        end
        ST_RUN: begin
          cnt <= cnt + 4'd1;
          if (cnt == RUN_END) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
            if (job.capture) begin
              bias_vld[job.rec] <= 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (finish) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // bias row memory: one read on job start, one write on end of a capture job
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job     <= q_job;
      bias_q  <= bias_mem[q_job.rec];
      bias_ok <= bias_vld[q_job.rec];
    end
    if (finish && job.capture) begin
      bias_mem[job.rec] <= cap_row;
    end
  end

  always_ff @(posedge clk) begin
    a_kind <= s_kind;
    a_axis <= s_axis;
    p1     <= prod_a[39:0];
    b_axis <= a_axis;
    p2     <= prod_b[48:0];
    if (a_vld) begin
      case (a_kind)
        ifds_pkg::KIND_ACC: acc_r[a_axis] <= p1;
        ifds_pkg::KIND_GYRO: begin
          cap_row[a_axis] <= p1;
          gyro_r[a_axis]  <= job.capture ? {p1[39], p1} : gyro_diff;
        end
        default: ;
      endcase
    end
    if (b_vld) begin
      cal_r[b_axis] <= rnd[48:8];
    end
    if (finish) begin
      res.imu_index     <= 5'(job.rec);
      res.acc_x         <= acc_r[0];
      res.acc_y         <= acc_r[1];
      res.acc_z         <= acc_r[2];
      res.gyro_x        <= gyro_r[0];
      res.gyro_y        <= gyro_r[1];
      res.gyro_z        <= gyro_r[2];
      res.mag_x         <= -cal_r[1];
      res.mag_y         <= -cal_r[0];
      res.mag_z         <= cal_r[2];
      res.last_in_frame <= job.last;
    end
  end

endmodule

// File: sv/imu_frame_decode_scale.sv
// Top level: configuration registers and front/queue/back of the IMU frame decoder.
//
//   channel  dir  width   contents
//   rx       in   8+1     rx_byte, frame_start
//   res      out  5+3x40+6x41+1  imu_index, acc/gyro/mag xyz, last_in_frame
//   cfg      in   1+3+24  cfg_we, cfg_index, cfg_data
//
// One byte transfers per cycle while the job queue has room at a record's last
// data byte. A result takes nine issues through the shared multiplier plus
// pipeline drain, so a 19-byte record does not stall the byte stream while res
// accepts results. A two-entry job queue lets bytes keep flowing while a result
// waits on res. Synchronous reset; no clearing pass.
module imu_frame_decode_scale (
  input  logic                               clk,
  input  logic                               rst,
  ifds_in_if.sink                            rx,
  ifds_out_if.source                         res,
  input  logic                               cfg_we,
  input  logic [ifds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ifds_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ifds_pkg::frame_cfg_t fcfg;
  ifds_pkg::scale_cfg_t scfg;
  logic                 q_full;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_valid;
  ifds_pkg::job_t       push_job;
  ifds_pkg::job_t       pop_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      fcfg.imu_count    <= ifds_pkg::IMU_COUNT_RST;
      fcfg.record_bytes <= ifds_pkg::RECORD_BYTES_RST;
      scfg.acc_scale    <= ifds_pkg::ACC_SCALE_RST;
      scfg.gyro_scale   <= ifds_pkg::GYRO_SCALE_RST;
      scfg.mag_scale    <= ifds_pkg::MAG_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ifds_pkg::REG_IMU_COUNT:    fcfg.imu_count    <= cfg_data[ifds_pkg::IMU_COUNT_W-1:0];
        ifds_pkg::REG_RECORD_BYTES: fcfg.record_bytes <= cfg_data[ifds_pkg::REC_BYTES_W-1:0];
        ifds_pkg::REG_ACC_SCALE:    scfg.acc_scale    <= cfg_data[ifds_pkg::SCALE_W-1:0];
        ifds_pkg::REG_GYRO_SCALE:   scfg.gyro_scale   <= cfg_data[ifds_pkg::SCALE_W-1:0];
        ifds_pkg::REG_MAG_SCALE:    scfg.mag_scale    <= cfg_data[ifds_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  ifds_front u_front (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .fcfg   (fcfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job)
  );

  ifds_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .pop_job  (pop_job)
  );

  ifds_back u_back (
    .clk     (clk),
    .rst     (rst),
    .scfg    (scfg),
    .q_valid (q_valid),
    .q_job   (pop_job),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule

// File: sv/ifds_check.sv
// Port-level checks for the IMU frame decoder, bound to the top level.
module ifds_check (
  input logic              clk,
  input logic              rst,
  input logic              rx_ready,
  input logic              res_valid,
  input logic              res_ready,
  input logic [4:0]        res_index,
  input logic signed [40:0] res_mag_z
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_index) && $stable(res_mag_z))
    else $error("result changed while stalled");

  a_reset_out: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  a_reset_ready: assert property (@(posedge clk) $past(rst) |-> rx_ready)
    else $error("byte input not ready right after reset");

endmodule

bind imu_frame_decode_scale ifds_check u_ifds_check (
  .clk       (clk),
  .rst       (rst),
  .rx_ready  (rx.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_index (res.imu_index),
  .res_mag_z (res.mag_z)
);

// File: test/ifds_checker.sv
// Checker for the IMU frame decoder: byte-level predictor and record scoreboard.
module ifds_checker (
  input  logic                            clk,
  input  logic                            rst,
  ifds_in_if                              rx,
  ifds_out_if                             res,
  input  logic                            cfg_we,
  input  logic [ifds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ifds_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              errors,
  output int                              outstanding,
  output int                              records_seen,
  output int                              frame_ends
);

  localparam int MAX_RECS    = 32;
  localparam int MIN_REC_LEN = 19;
  localparam int MAX_REC_LEN = 64;
  localparam int LAST_BYTE   = 18;
  localparam int TABLE_LEN   = 51;
  localparam int MAX_SHOWN   = 10;

  localparam logic [7:0] MAG_TRIM [TABLE_LEN] = '{
    8'd181, 8'd181, 8'd169, 8'd174, 8'd175, 8'd163, 8'd175, 8'd174, 8'd163,
    8'd176, 8'd179, 8'd166, 8'd181, 8'd183, 8'd170, 8'd177, 8'd178, 8'd166,
    8'd170, 8'd173, 8'd159, 8'd170, 8'd172, 8'd159, 8'd177, 8'd178, 8'd167,
    8'd176, 8'd178, 8'd166, 8'd177, 8'd177, 8'd165, 8'd176, 8'd177, 8'd164,
    8'd179, 8'd179, 8'd168, 8'd174, 8'd174, 8'd162, 8'd182, 8'd183, 8'd170,
    8'd171, 8'd169, 8'd158, 8'd178, 8'd180, 8'd168
  };

  typedef struct {
    logic [4:0]         imu;
    logic signed [40:0] val [9];
    logic               last;
  } imu_record_t;

  string field_name [9] = '{"acc_x", "acc_y", "acc_z", "gyro_x", "gyro_y", "gyro_z",
                            "mag_x", "mag_y", "mag_z"};

  imu_record_t predicted_records [$];

  logic [5:0]  n_imus;
  logic [6:0]  rec_len;
  logic [23:0] acc_k;
  logic [23:0] gyro_k;
  logic [23:0] mag_k;

  int unsigned byte_pos;
  int unsigned rec_pos;
  logic [7:0]  hi_hold;
  logic [15:0] words [9];
  longint      bias [MAX_RECS*3];
  bit          bias_done;
  logic [7:0]  trim [MAX_RECS*3];

  function automatic void write_register(input logic [ifds_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [ifds_pkg::CFG_DATA_W-1:0] d);
    case (idx)
      ifds_pkg::REG_IMU_COUNT:    n_imus  = d[5:0];
      ifds_pkg::REG_RECORD_BYTES: rec_len = d[6:0];
      ifds_pkg::REG_ACC_SCALE:    acc_k   = d[23:0];
      ifds_pkg::REG_GYRO_SCALE:   gyro_k  = d[23:0];
      ifds_pkg::REG_MAG_SCALE:    mag_k   = d[23:0];
      default: ;
    endcase
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic fs);
    int unsigned cnt;
    int unsigned rl;
    int unsigned pos;
    int unsigned rec;
    bit          last;
    longint      acc_v;
    longint      g;
    longint      p;
    longint      mag_c [3];
    imu_record_t s;
    cnt = n_imus;
    if (cnt < 1) cnt = 1;
    if (cnt > MAX_RECS) cnt = MAX_RECS;
    rl = rec_len;
    if (rl < MIN_REC_LEN) rl = MIN_REC_LEN;
    if (rl > MAX_REC_LEN) rl = MAX_REC_LEN;
    if (fs) begin
      byte_pos = 0;
      rec_pos  = 0;
    end
    pos  = byte_pos;
    rec  = rec_pos;
    last = (rec >= cnt - 1);
    if (pos >= 1 && pos <= LAST_BYTE) begin
      if (pos % 2 == 1) hi_hold = b;
      else words[(pos - 2) / 2] = {hi_hold, b};
    end
    if (pos == LAST_BYTE && rec < MAX_RECS) begin
      for (int a = 0; a < 3; a++) begin
        acc_v = longint'($signed(words[a])) * longint'(acc_k);
        g     = longint'($signed(words[3 + a])) * longint'(gyro_k);
        if (!bias_done) bias[rec * 3 + a] = g;
        else g -= bias[rec * 3 + a];
        p = longint'($signed(words[6 + a])) * longint'(mag_k)
            * longint'({1'b0, trim[rec * 3 + a]} + 9'd128);
        // divide by 256, ties go up
        mag_c[a]   = (p + 128) >>> 8;
        s.val[a]   = acc_v[40:0];
        s.val[3+a] = g[40:0];
      end
      s.val[6] = 41'(-mag_c[1]);
      s.val[7] = 41'(-mag_c[0]);
      s.val[8] = 41'(mag_c[2]);
      s.imu    = 5'(rec);
      s.last   = last;
      predicted_records.push_back(s);
      if (last) bias_done = 1'b1;
    end
    if (pos + 1 >= rl) begin
      byte_pos = 0;
      rec_pos  = last ? 0 : rec + 1;
    end else begin
      byte_pos = pos + 1;
    end
  endfunction

  function automatic void flag(input logic [4:0] imu, input string what,
                               input longint want_v, input longint got_v);
    errors++;
    if (errors <= MAX_SHOWN)
      $display("record %0d %s: expected %0d, got %0d", imu, what, want_v, got_v);
  endfunction

  function automatic void check_record();
    imu_record_t want;
    imu_record_t got;
    got.imu    = res.imu_index;
    got.val[0] = res.acc_x;
    got.val[1] = res.acc_y;
    got.val[2] = res.acc_z;
    got.val[3] = res.gyro_x;
    got.val[4] = res.gyro_y;
    got.val[5] = res.gyro_z;
    got.val[6] = res.mag_x;
    got.val[7] = res.mag_y;
    got.val[8] = res.mag_z;
    got.last   = res.last_in_frame;
    records_seen++;
    if (got.last === 1'b1) frame_ends++;
    if (predicted_records.size() == 0) begin
      errors++;
      if (errors <= MAX_SHOWN) $display("record %0d transferred with none predicted", got.imu);
    end else begin
      want = predicted_records.pop_front();
      if (got.imu !== want.imu) flag(want.imu, "imu_index", want.imu, got.imu);
      for (int i = 0; i < 9; i++) begin
        if (got.val[i] !== want.val[i]) flag(want.imu, field_name[i], want.val[i], got.val[i]);
      end
      if (got.last !== want.last) flag(want.imu, "last_in_frame", want.last, got.last);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      n_imus    = 6'd17;
      rec_len   = 7'd19;
      acc_k     = 24'd2048;
      gyro_k    = 24'd1024033;
      mag_k     = 24'd2457862;
      byte_pos  = 0;
      rec_pos   = 0;
      hi_hold   = '0;
      bias_done = 1'b0;
      for (int i = 0; i < 9; i++) words[i] = '0;
      for (int i = 0; i < MAX_RECS * 3; i++) begin
        bias[i] = 0;
        if (i < TABLE_LEN) trim[i] = MAG_TRIM[i];
        else trim[i] = 8'd128;
      end
      predicted_records.delete();
      errors       = 0;
      records_seen = 0;
      frame_ends   = 0;
    end else begin
      if (res.valid && res.ready) check_record();
      if (cfg_we) write_register(cfg_index, cfg_data);
      if (rx.valid && rx.ready) decode_byte(rx.rx_byte, rx.frame_start);
    end
    outstanding = predicted_records.size();
  end

endmodule

// File: test/tb_top.sv
// Testbench top for the IMU frame decoder: clock, reset, stimulus and verdict.
module tb_top;

  localparam logic [ifds_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [ifds_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int TOTAL_BYTES  = 1750;
  localparam int QUIET_BYTES  = 250;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 300;
  localparam int BIG_FRAME    = 320;

  logic clk = 1'b0;
  logic rst;
  logic                            cfg_we;
  logic [ifds_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ifds_pkg::CFG_DATA_W-1:0] cfg_data;

  int errors;
  int outstanding;
  int records_seen;
  int frame_ends;
  int bytes_sent;
  int settings_used;
  int eff_count;
  int eff_rlen;
  bit in_gaps;
  bit out_gaps;
  bit hold_req;

  always #5 clk = ~clk;

  ifds_in_if  rx ();
  ifds_out_if res ();

  imu_frame_decode_scale u_dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ifds_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .rx           (rx),
    .res          (res),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .outstanding  (outstanding),
    .records_seen (records_seen),
    .frame_ends   (frame_ends)
  );

  function automatic logic [23:0] pick_scale();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 24'd1;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [8:0][15:0] rand_words();
    logic [15:0]      corner_words [7];
    logic [8:0][15:0] w;
    corner_words = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h0080, 16'hFF80};
    for (int i = 0; i < 9; i++) begin
      if ($urandom_range(0, 3) == 0) w[i] = corner_words[$urandom_range(0, 6)];
      else w[i] = 16'($urandom);
    end
    return w;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fs);
    if (in_gaps && $urandom_range(0, 7) == 0) begin
      rx.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    rx.valid       <= 1'b1;
    rx.rx_byte     <= b;
    rx.frame_start <= fs;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_record(input logic fs, input logic [8:0][15:0] w);
    logic [7:0] b;
    send_byte(8'($urandom), fs);
    for (int i = 1; i < eff_rlen; i++) begin
      if (i > 18) b = 8'($urandom);
      else if (i % 2 == 1) b = w[(i - 1) / 2][15:8];
      else b = w[(i - 2) / 2][7:0];
      send_byte(b, 1'b0);
    end
  endtask

  task automatic send_frame(input int n_rec, input logic fs);
    for (int r = 0; r < n_rec; r++) send_record(fs && r == 0, rand_words());
  endtask

  // wait for every predicted record, then for the back end to drain
  task automatic settle();
    rx.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ifds_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ifds_pkg::CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [5:0] n, input logic [6:0] rl,
                            input logic [23:0] a, input logic [23:0] g, input logic [23:0] m);
    write_reg(ifds_pkg::REG_IMU_COUNT, {18'($urandom), n});
    write_reg(ifds_pkg::REG_RECORD_BYTES, {17'($urandom), rl});
    write_reg(ifds_pkg::REG_ACC_SCALE, a);
    write_reg(ifds_pkg::REG_GYRO_SCALE, g);
    write_reg(ifds_pkg::REG_MAG_SCALE, m);
    write_reg(ifds_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 24'($urandom));
    cfg_we <= 1'b0;
    eff_count = (n == 0) ? 1 : ((n > ifds_pkg::MAX_IMUS) ? ifds_pkg::MAX_IMUS : n);
    eff_rlen  = (rl < ifds_pkg::REC_BYTES_MIN) ? ifds_pkg::REC_BYTES_MIN
              : ((rl > ifds_pkg::REC_BYTES_MAX) ? ifds_pkg::REC_BYTES_MAX : rl);
    settings_used++;
  endtask

  task automatic random_phase();
    logic [5:0] n;
    logic [6:0] rl;
    int         budget;
    case ($urandom_range(0, 9))
      0: n = 6'd0;
      1: n = 6'($urandom_range(33, 63));
      default: n = 6'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 9))
      0: rl = 7'($urandom_range(0, 18));
      1: rl = 7'($urandom_range(65, 127));
      2: rl = 7'd64;
      default: rl = 7'($urandom_range(19, 24));
    endcase
    settle();
    set_config(n, rl, pick_scale(), pick_scale(), pick_scale());
    if (bytes_sent >= TOTAL_BYTES - QUIET_BYTES) begin
      in_gaps  = 1'b0;
      out_gaps = 1'b0;
    end else begin
      in_gaps  = ($urandom_range(0, 3) != 0);
      out_gaps = ($urandom_range(0, 3) != 0);
    end
    budget = bytes_sent + $urandom_range(60, 160);
    // pick up where the previous setting left the frame
    if ($urandom_range(0, 2) == 0) send_frame(1, 1'b0);
    while (bytes_sent < budget) begin
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 30)) send_byte(8'($urandom), $urandom_range(0, 15) == 0);
        1: send_frame($urandom_range(1, 3), 1'b0);
        default: send_frame((eff_count * eff_rlen <= BIG_FRAME) ? eff_count
                                                                : $urandom_range(1, 3), 1'b1);
      endcase
    end
  endtask

  initial begin
    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    res.ready <= 1'b0;
    wait (!rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (out_gaps && $urandom_range(0, 5) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        res.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    rx.valid       <= 1'b0;
    rx.rx_byte     <= '0;
    rx.frame_start <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= ifds_pkg::REG_IMU_COUNT;
    cfg_data       <= '0;
    in_gaps        = 1'b1;
    out_gaps       = 1'b1;
    hold_req       = 1'b0;
    bytes_sent     = 0;
    settings_used  = 0;
    eff_count      = ifds_pkg::IMU_COUNT_RST;
    eff_rlen       = ifds_pkg::RECORD_BYTES_RST;
    wait (!rst);
    @(posedge clk);

    // full-scale and small words, then a frame restart mid-record
    send_record(1'b1, {16'h0080, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h7FFF, 16'h8000,
                       16'h0001, 16'h8000, 16'h7FFF});
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);

    // first full frame captures the gyro bias
    send_frame(eff_count, 1'b1);

    // one record per frame, counts wrap without frame_start
    settle();
    set_config(6'd1, 7'd19, '1, '1, '1);
    send_frame(4, 1'b1);

    // zero count and short records clamp up
    settle();
    set_config(6'd0, 7'd0, '0, '0, '0);
    send_frame(3, 1'b1);

    // oversize count and records clamp down
    settle();
    set_config(6'd63, 7'd127, 24'd1, 24'd1, 24'd1);
    send_frame(2, 1'b1);

    // widest frame; output held off long enough to back up the input
    settle();
    set_config(6'd32, 7'd19, pick_scale(), pick_scale(), 24'd1);
    hold_req = 1'b1;
    send_frame(ifds_pkg::MAX_IMUS + 1, 1'b1);

    // record count lowered below the current record
    settle();
    set_config(6'd8, 7'd20, pick_scale(), pick_scale(), pick_scale());
    send_frame(5, 1'b1);
    settle();
    set_config(6'd2, 7'd20, pick_scale(), pick_scale(), pick_scale());
    send_frame(2, 1'b0);

    while (bytes_sent < TOTAL_BYTES) random_phase();

    settle();
    $display("Sent %0d bytes under %0d register settings; checked %0d records, %0d frame ends.",
             bytes_sent, settings_used, records_seen, frame_ends);
    $display("Mismatches: %0d, records still awaited: %0d", errors, outstanding);
    if (errors == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
